>>> rtl/ofrq_pkg.sv
// ----------------------------------------------------------------------------
// ofrq_pkg
// Shared command, packet type and result codes of the ordered fragment reassembly queue.
// ----------------------------------------------------------------------------
package ofrq_pkg;

  localparam logic CMD_ARRIVE  = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  localparam logic [1:0] PT_FULL   = 2'd0;
  localparam logic [1:0] PT_FIRST  = 2'd1;
  localparam logic [1:0] PT_MIDDLE = 2'd2;
  localparam logic [1:0] PT_LAST   = 2'd3;

  localparam logic [2:0] K_STORED   = 3'd0;
  localparam logic [2:0] K_TOO_OLD  = 3'd1;
  localparam logic [2:0] K_DUP      = 3'd2;
  localparam logic [2:0] K_FULL     = 3'd3;
  localparam logic [2:0] K_RELEASED = 3'd4;
  localparam logic [2:0] K_NONE     = 3'd5;

endpackage

>>> rtl/ofrq_if.sv
// ----------------------------------------------------------------------------
// ofrq_in_if / ofrq_out_if
// Valid/ready channels of the reassembly queue.
// ----------------------------------------------------------------------------
interface ofrq_in_if #(parameter int ID_BITS = 16, parameter int SLOT_W = 5);
  logic               valid;
  logic               ready;
  logic               command;
  logic [ID_BITS-1:0] packet_id;
  logic [1:0]         packet_type;
  logic [SLOT_W-1:0]  payload_slot;
  modport source(output valid, command, packet_id, packet_type, payload_slot, input ready);
  modport sink(input valid, command, packet_id, packet_type, payload_slot, output ready);
endinterface

interface ofrq_out_if #(parameter int SLOT_W = 5);
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [SLOT_W-1:0] slot;
  logic              delivered;
  logic              message_end;
  logic              last;
  modport source(output valid, kind, slot, delivered, message_end, last, input ready);
  modport sink(input valid, kind, slot, delivered, message_end, last, output ready);
endinterface

>>> rtl/ofrq_front.sv
// ----------------------------------------------------------------------------
// ofrq_front
// Input stage: takes items into a two-entry command queue.
// ----------------------------------------------------------------------------
module ofrq_front #(
  parameter int ID_BITS = 16,
  parameter int SLOT_W  = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [ID_BITS-1:0] in_packet_id,
  input  logic [1:0]         in_packet_type,
  input  logic [SLOT_W-1:0]  in_payload_slot,
  output logic               q_valid,
  input  logic               q_pop,
  output logic               q_command,
  output logic [ID_BITS-1:0] q_id,
  output logic [1:0]         q_type,
  output logic [SLOT_W-1:0]  q_slot
);
  localparam int W = 1 + ID_BITS + 2 + SLOT_W;
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign {q_command, q_id, q_type, q_slot} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) mem_r[wp_r] <= {in_command, in_packet_id, in_packet_type, in_payload_slot};
  end
endmodule

>>> rtl/ofrq_back.sv
// ----------------------------------------------------------------------------
// ofrq_back
// Engine: ordered insert, run scan, release, compact; one command at a time.
// ----------------------------------------------------------------------------
module ofrq_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 16,
  parameter int SLOT_W      = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic               q_command,
  input  logic [ID_BITS-1:0] q_id,
  input  logic [1:0]         q_type,
  input  logic [SLOT_W-1:0]  q_slot,
  output logic               o_valid,
  input  logic               o_ready,
  output logic [2:0]         o_kind,
  output logic [SLOT_W-1:0]  o_slot,
  output logic               o_delivered,
  output logic               o_message_end,
  output logic               o_last,
  output logic               busy
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [ID_BITS-1:0] HALF = {1'b1, {(ID_BITS-1){1'b0}}};
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_SHIFT, S_SCAN, S_REL, S_COMPACT
  } state_t;

  logic [ID_BITS-1:0] ids_r   [QUEUE_DEPTH];
  logic [1:0]         types_r [QUEUE_DEPTH];
  logic [SLOT_W-1:0]  slots_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] dlv_r, mend_r;

  state_t             st_r;
  logic [CW-1:0]      cnt_r, i_r, pos_r, start_r, newest_r, rel_r;
  logic               any_r, inrun_r;
  logic [ID_BITS-1:0] exp_r, last_id_r, cid_r;
  logic [1:0]         ctype_r;
  logic [SLOT_W-1:0]  cslot_r;

  function automatic logic newer(input logic [ID_BITS-1:0] a, input logic [ID_BITS-1:0] b);
    logic [ID_BITS-1:0] d;
    d = a - b;
    return ((d != '0) && (d < HALF)) || ((d == HALF) && (a > b));
  endfunction

  logic [IW-1:0] ii, im1;
  assign ii  = i_r[IW-1:0];
  assign im1 = IW'(i_r - CW'(1));

  assign busy  = (st_r != S_IDLE);
  assign q_pop = (st_r == S_IDLE) && q_valid && !o_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      last_id_r <= '1;
      o_valid   <= 1'b0;
    end else begin
      if (o_valid && o_ready) o_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (q_pop) begin
          cid_r   <= q_id;
          ctype_r <= q_type;
          cslot_r <= q_slot;
          i_r     <= '0;
          if (q_command == ofrq_pkg::CMD_ARRIVE) begin
            o_slot <= q_slot; o_delivered <= 1'b0; o_message_end <= 1'b0; o_last <= 1'b1;
            if (!newer(q_id, last_id_r)) begin
              o_kind <= ofrq_pkg::K_TOO_OLD; o_valid <= 1'b1;
            end else if (cnt_r != '0 && newer(q_id, ids_r[IW'(cnt_r - CW'(1))])) begin
              if (cnt_r == DEPTH_C) begin
                o_kind <= ofrq_pkg::K_FULL; o_valid <= 1'b1;
              end else begin
                pos_r <= cnt_r; i_r <= cnt_r; st_r <= S_SHIFT;
              end
            end else if (cnt_r == '0) begin
              pos_r <= '0; i_r <= '0; st_r <= S_SHIFT;
            end else begin
              st_r <= S_FIND;
            end
          end else begin
            any_r <= 1'b0; inrun_r <= 1'b0; newest_r <= '0;
            dlv_r <= '0; mend_r <= '0;
            st_r  <= S_SCAN;
          end
        end
        S_FIND: begin
          if (i_r == cnt_r) begin
            if (cnt_r == DEPTH_C) begin
              o_kind <= ofrq_pkg::K_FULL; o_valid <= 1'b1; st_r <= S_IDLE;
            end else begin
              pos_r <= cnt_r; st_r <= S_SHIFT;
            end
          end else if (ids_r[ii] == cid_r) begin
            o_kind <= ofrq_pkg::K_DUP; o_valid <= 1'b1; st_r <= S_IDLE;
          end else if (newer(ids_r[ii], cid_r)) begin
            if (cnt_r == DEPTH_C) begin
              o_kind <= ofrq_pkg::K_FULL; o_valid <= 1'b1; st_r <= S_IDLE;
            end else begin
              pos_r <= i_r; i_r <= cnt_r; st_r <= S_SHIFT;
            end
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_SHIFT: begin
          if (i_r == pos_r) begin
            ids_r[ii] <= cid_r; types_r[ii] <= ctype_r; slots_r[ii] <= cslot_r;
            cnt_r   <= cnt_r + CW'(1);
            o_kind  <= ofrq_pkg::K_STORED; o_valid <= 1'b1;
            st_r    <= S_IDLE;
          end else begin
            ids_r[ii] <= ids_r[im1]; types_r[ii] <= types_r[im1];
            slots_r[ii] <= slots_r[im1];
            i_r <= i_r - CW'(1);
          end
        end
        S_SCAN: begin
          if (i_r == cnt_r) begin
            if (!any_r) begin
              o_kind <= ofrq_pkg::K_NONE; o_slot <= '0; o_delivered <= 1'b0;
              o_message_end <= 1'b0; o_last <= 1'b1; o_valid <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              last_id_r <= ids_r[IW'(newest_r)];
              rel_r <= newest_r + CW'(1);
              i_r   <= '0;
              st_r  <= S_REL;
            end
          end else if (inrun_r && ids_r[ii] == exp_r && types_r[ii] == ofrq_pkg::PT_LAST) begin
            for (int j = 0; j < QUEUE_DEPTH; j++)
              if (CW'(j) >= start_r && CW'(j) <= i_r) dlv_r[j] <= 1'b1;
            mend_r[ii] <= 1'b1;
            newest_r <= i_r; any_r <= 1'b1; inrun_r <= 1'b0;
            i_r <= i_r + CW'(1);
          end else if (inrun_r && ids_r[ii] == exp_r && types_r[ii] == ofrq_pkg::PT_MIDDLE) begin
            exp_r <= exp_r + ID_BITS'(1);
            i_r <= i_r + CW'(1);
          end else if (inrun_r) begin
            inrun_r <= 1'b0;
          end else if (types_r[ii] == ofrq_pkg::PT_FULL) begin
            dlv_r[ii] <= 1'b1; mend_r[ii] <= 1'b1;
            newest_r <= i_r; any_r <= 1'b1;
            i_r <= i_r + CW'(1);
          end else if (types_r[ii] == ofrq_pkg::PT_FIRST) begin
            inrun_r <= 1'b1; start_r <= i_r;
            exp_r <= ids_r[ii] + ID_BITS'(1);
            i_r <= i_r + CW'(1);
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_REL: if (!o_valid || o_ready) begin
          o_kind <= ofrq_pkg::K_RELEASED; o_slot <= slots_r[ii];
          o_delivered <= dlv_r[ii]; o_message_end <= mend_r[ii];
          o_last <= (i_r + CW'(1) == rel_r); o_valid <= 1'b1;
          if (i_r + CW'(1) == rel_r) begin
            i_r <= '0; st_r <= S_COMPACT;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_COMPACT: begin
          if (i_r + rel_r >= cnt_r) begin
            cnt_r <= cnt_r - rel_r; st_r <= S_IDLE;
          end else begin
            ids_r[ii]   <= ids_r[IW'(i_r + rel_r)];
            types_r[ii] <= types_r[IW'(i_r + rel_r)];
            slots_r[ii] <= slots_r[IW'(i_r + rel_r)];
            i_r <= i_r + CW'(1);
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/ordered_fragment_reassembly_queue.sv
// ----------------------------------------------------------------------------
// ordered_fragment_reassembly_queue
// Receive-side reorder and reassembly of packet descriptors.
// Arrival: search for the insert position, then shift by one entry a cycle.
// Process: scan the pending entries for complete messages, then release every entry up to
// the newest complete one and move the remaining entries down.
// Throughput bound by the single back-end engine; a 2-entry queue decouples input.
// Reset (synchronous, rst_n low): queue empty, newest delivered id all ones.
// ----------------------------------------------------------------------------
module ordered_fragment_reassembly_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SLOT_COUNT  = 32,
  parameter int ID_BITS     = 16
) (
  input logic clk,
  input logic rst_n,
  ofrq_in_if.sink    in_ch,
  ofrq_out_if.source out_ch
);
  localparam int SLOT_W = $clog2(SLOT_COUNT);

  logic               q_valid, q_pop, q_command, busy;
  logic [ID_BITS-1:0] q_id;
  logic [1:0]         q_type;
  logic [SLOT_W-1:0]  q_slot;

  ofrq_front #(.ID_BITS(ID_BITS), .SLOT_W(SLOT_W)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_command(in_ch.command),
    .in_packet_id(in_ch.packet_id), .in_packet_type(in_ch.packet_type),
    .in_payload_slot(in_ch.payload_slot),
    .q_valid, .q_pop, .q_command, .q_id, .q_type, .q_slot
  );

  ofrq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS), .SLOT_W(SLOT_W)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_command, .q_id, .q_type, .q_slot,
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_kind(out_ch.kind),
    .o_slot(out_ch.slot), .o_delivered(out_ch.delivered),
    .o_message_end(out_ch.message_end), .o_last(out_ch.last), .busy
  );

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !busy)
    else $error("pop while busy");
  a_dlv_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.delivered |-> out_ch.kind == ofrq_pkg::K_RELEASED)
    else $error("delivered on non-release");
  a_mend: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.message_end |-> out_ch.delivered)
    else $error("message end without delivery");
endmodule

>>> bench/tb_ordered_fragment_reassembly_queue.sv
// ----------------------------------------------------------------------------
// tb_ordered_fragment_reassembly_queue
// Drives arrivals and process commands into the reassembly queue and checks
// every result item against a behavioral predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_ordered_fragment_reassembly_queue;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] slot;
    logic       delivered;
    logic       message_end;
    logic       last;
  } result_t;

  class reassembly_scoreboard;
    logic [15:0] q_id[16];
    logic [1:0]  q_type[16];
    logic [4:0]  q_slot[16];
    int          q_count;
    logic [15:0] newest_id;
    result_t     expected_q[$];
    int          errors;

    function new();
      q_count = 0;
      newest_id = 16'hFFFF;
      errors = 0;
    endfunction

    function bit is_newer(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return (d != 16'd0 && d < 16'h8000) || (d == 16'h8000 && a > b);
    endfunction

    function void push(logic [2:0] k, logic [4:0] s, logic dl, logic me, logic ls);
      result_t r;
      r.kind = k; r.slot = s; r.delivered = dl; r.message_end = me; r.last = ls;
      expected_q = {expected_q, r};
    endfunction

    function void note_item(logic cmd, logic [15:0] id, logic [1:0] ty, logic [4:0] sl);
      int pos, i, j, start, newest, rel;
      logic [15:0] want;
      bit any, done;
      bit dl[16];
      bit me[16];
      if (cmd == ofrq_pkg::CMD_ARRIVE) begin
        pos = q_count;
        if (!is_newer(id, newest_id)) begin
          push(ofrq_pkg::K_TOO_OLD, sl, 1'b0, 1'b0, 1'b1);
          return;
        end
        if (q_count != 0 && !is_newer(id, q_id[q_count-1])) begin
          for (i = 0; i < q_count; i++)
            if (q_id[i] == id || is_newer(q_id[i], id)) begin
              pos = i;
              break;
            end
          if (pos < q_count && q_id[pos] == id) begin
            push(ofrq_pkg::K_DUP, sl, 1'b0, 1'b0, 1'b1);
            return;
          end
        end
        if (q_count >= 16) begin
          push(ofrq_pkg::K_FULL, sl, 1'b0, 1'b0, 1'b1);
          return;
        end
        for (i = q_count; i > pos; i--) begin
          q_id[i] = q_id[i-1]; q_type[i] = q_type[i-1]; q_slot[i] = q_slot[i-1];
        end
        q_id[pos] = id; q_type[pos] = ty; q_slot[pos] = sl;
        q_count++;
        push(ofrq_pkg::K_STORED, sl, 1'b0, 1'b0, 1'b1);
        return;
      end
      for (i = 0; i < 16; i++) begin dl[i] = 1'b0; me[i] = 1'b0; end
      any = 1'b0; newest = 0; i = 0;
      while (i < q_count) begin
        if (q_type[i] == ofrq_pkg::PT_FULL) begin
          dl[i] = 1'b1; me[i] = 1'b1; newest = i; any = 1'b1; i++;
        end else if (q_type[i] == ofrq_pkg::PT_FIRST) begin
          start = i; want = q_id[i] + 16'd1; done = 1'b0; i++;
          while (i < q_count && q_id[i] == want) begin
            if (q_type[i] == ofrq_pkg::PT_LAST) begin done = 1'b1; break; end
            if (q_type[i] != ofrq_pkg::PT_MIDDLE) break;
            i++; want = want + 16'd1;
          end
          if (done) begin
            for (j = start; j <= i; j++) dl[j] = 1'b1;
            me[i] = 1'b1; newest = i; any = 1'b1; i++;
          end
        end else begin
          i++;
        end
      end
      if (!any) begin
        push(ofrq_pkg::K_NONE, 5'd0, 1'b0, 1'b0, 1'b1);
        return;
      end
      newest_id = q_id[newest];
      rel = newest + 1;
      for (i = 0; i < rel; i++)
        push(ofrq_pkg::K_RELEASED, q_slot[i], dl[i], me[i], i + 1 == rel);
      for (j = rel; j < q_count; j++) begin
        q_id[j-rel] = q_id[j]; q_type[j-rel] = q_type[j]; q_slot[j-rel] = q_slot[j];
      end
      q_count = q_count - rel;
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  ofrq_in_if  in_ch();
  ofrq_out_if out_ch();
  reassembly_scoreboard sb;
  bit long_hold = 0;
  bit stim_done = 0;
  logic [15:0] base_id;

  ordered_fragment_reassembly_queue dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  function int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task send_item(logic cmd, logic [15:0] id, logic [1:0] ty, logic [4:0] sl);
    int g;
    g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.packet_id <= id;
    in_ch.packet_type <= ty;
    in_ch.payload_slot <= sl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(cmd, id, ty, sl);
  endtask

  task go_idle();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task send_message(logic [15:0] id, int frags);
    int k;
    if (frags == 1) send_item(ofrq_pkg::CMD_ARRIVE, id, ofrq_pkg::PT_FULL, 5'($urandom));
    else for (k = 0; k < frags; k++)
      send_item(ofrq_pkg::CMD_ARRIVE, id + 16'(k),
                k == 0 ? ofrq_pkg::PT_FIRST :
                (k == frags - 1 ? ofrq_pkg::PT_LAST : ofrq_pkg::PT_MIDDLE),
                5'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(result_t'({out_ch.kind, out_ch.slot, out_ch.delivered,
                                 out_ch.message_end, out_ch.last}));
  end

  initial begin
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 0;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        repeat (gap_len()) @(posedge clk);
        out_ch.ready <= 1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("** ordered_fragment_reassembly_queue: FAILED **");
    $finish;
  end

  initial begin
    int n, k, order[8], t, tmp, wait_cnt;
    sb = new();
    in_ch.valid = 0; in_ch.command = 0; in_ch.packet_id = 0;
    in_ch.packet_type = 0; in_ch.payload_slot = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty process, too old, extremes, fragments, stray, duplicate, full queue
    send_item(ofrq_pkg::CMD_PROCESS, 16'hFFFF, 2'd3, 5'd31);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'hFFFF, ofrq_pkg::PT_FULL, 5'd31);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h8000, ofrq_pkg::PT_LAST, 5'd1);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h7FFF, ofrq_pkg::PT_FULL, 5'd2);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0000, ofrq_pkg::PT_FULL, 5'd0);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0000, ofrq_pkg::PT_MIDDLE, 5'd3);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0002, ofrq_pkg::PT_FIRST, 5'd4);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0004, ofrq_pkg::PT_LAST, 5'd5);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0001, ofrq_pkg::PT_MIDDLE, 5'd6);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0006, ofrq_pkg::PT_FIRST, 5'd7);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0007, ofrq_pkg::PT_MIDDLE, 5'd8);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0008, ofrq_pkg::PT_LAST, 5'd9);
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0005, ofrq_pkg::PT_FULL, 5'd10);
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0003, ofrq_pkg::PT_MIDDLE, 5'd11);
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    for (k = 0; k < 17; k++)
      send_item(ofrq_pkg::CMD_ARRIVE, 16'h0100 + 16'(k), ofrq_pkg::PT_MIDDLE, 5'(k));
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0099, ofrq_pkg::PT_FULL, 5'd12);
    send_item(ofrq_pkg::CMD_ARRIVE, 16'h0050, ofrq_pkg::PT_FULL, 5'd13);
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    base_id = sb.newest_id + 16'd1;
    // pause until drained
    go_idle();
    wait_cnt = 0;
    while (sb.expected_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk); wait_cnt++;
    end
    // fill while the receiver holds off
    long_hold = 1;
    for (k = 0; k < 20; k++)
      send_item(ofrq_pkg::CMD_ARRIVE, base_id + 16'(k), ofrq_pkg::PT_FULL, 5'($urandom));
    send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
    base_id = sb.newest_id + 16'd1;
    // random: shuffled well-formed groups plus noise
    n = 0;
    while (n < 310) begin
      t = $urandom_range(0, 9);
      if (t < 7) begin
        for (k = 0; k < 8; k++) order[k] = k;
        for (k = 7; k > 0; k--) begin
          tmp = $urandom_range(0, k);
          {order[k], order[tmp]} = {order[tmp], order[k]};
        end
        for (k = 0; k < 8; k++) begin
          if (order[k] < 5) begin
            send_item(ofrq_pkg::CMD_ARRIVE, base_id + 16'(order[k]),
                      order[k] == 0 ? ofrq_pkg::PT_FULL : order[k] == 1 ? ofrq_pkg::PT_FIRST :
                      order[k] == 4 ? ofrq_pkg::PT_LAST : ofrq_pkg::PT_MIDDLE, 5'($urandom));
            n++;
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          send_item(ofrq_pkg::CMD_ARRIVE, base_id + 16'($urandom_range(0, 4)),
                    2'($urandom), 5'($urandom));
          n++;
        end
        send_item(ofrq_pkg::CMD_PROCESS, 16'($urandom), 2'($urandom), 5'($urandom)); n++;
        base_id = base_id + 16'd5 + 16'($urandom_range(0, 1));
      end else if (t < 9) begin
        send_item(ofrq_pkg::CMD_ARRIVE,
                  $urandom_range(0, 1) ? 16'($urandom) : base_id + 16'($urandom_range(0, 20)),
                  2'($urandom), 5'($urandom));
        n++;
      end else begin
        send_message(base_id + 16'($urandom_range(0, 2)), $urandom_range(1, 4));
        send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0);
        n += 3;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(ofrq_pkg::CMD_PROCESS, 16'd0, 2'd0, 5'd0); n++;
      end
      base_id = sb.newest_id + 16'd1;
    end
    go_idle();
    stim_done = 1;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("** ordered_fragment_reassembly_queue: PASSED **");
    else
      $display("** ordered_fragment_reassembly_queue: FAILED **");
    $finish;
  end
endmodule

>>> sim.f
rtl/ofrq_pkg.sv
rtl/ofrq_if.sv
rtl/ofrq_front.sv
rtl/ofrq_back.sv
rtl/ordered_fragment_reassembly_queue.sv
bench/tb_ordered_fragment_reassembly_queue.sv
